@@ hdl/lss_pkg.sv @@
// ----------------------------------------------------------------------------
// lss_pkg
// Shared types and constants of the Laplacian sharpening stream.
// ----------------------------------------------------------------------------
package lss_pkg;

  localparam int MAX_WIDTH = 2048;
  localparam int COL_W     = $clog2(MAX_WIDTH);
  localparam int ROW_W     = 17;               // runs one row past the height while flushing
  localparam int Q_DEPTH   = 4;
  localparam int QCNT_W    = $clog2(Q_DEPTH + 1);

  localparam logic [1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [1:0] REG_FRAME_HEIGHT = 2'd1;
  localparam logic [1:0] REG_STRENGTH     = 2'd2;

  localparam logic [11:0] WIDTH_RST    = 12'd640;
  localparam logic [15:0] HEIGHT_RST   = 16'd480;
  localparam logic [11:0] STRENGTH_RST = 12'd256;

  // one centre pixel with its four neighbours, ready for the arithmetic
  typedef struct packed {
    logic [7:0]  alpha;
    logic [23:0] cm;
    logic [23:0] cl;
    logic [23:0] cr;
    logic [23:0] ct;
    logic [23:0] cb;
    logic        last;
  } job_t;

  typedef struct packed {
    logic valid;
    job_t job;
  } push_t;

endpackage

@@ hdl/lss_ram.sv @@
// ----------------------------------------------------------------------------
// lss_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module lss_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

@@ hdl/lss_fifo.sv @@
// ----------------------------------------------------------------------------
// lss_fifo
// Short job queue between the windowing front and the arithmetic back.
// ----------------------------------------------------------------------------
module lss_fifo (
  input  logic                         clk,
  input  logic                         rst_n,
  input  lss_pkg::push_t               push,
  input  logic                         pop_req,
  output logic                         head_valid,
  output lss_pkg::job_t                head,
  output logic [lss_pkg::QCNT_W-1:0]   count
);

  localparam int PTR_W = $clog2(lss_pkg::Q_DEPTH);

  lss_pkg::job_t              mem_r [lss_pkg::Q_DEPTH];
  logic [PTR_W-1:0]           wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [lss_pkg::QCNT_W-1:0] cnt_r, cnt_nxt;
  logic                       do_pop;

  assign head_valid = (cnt_r != '0);
  assign head       = mem_r[rd_ptr_r];
  assign count      = cnt_r;
  assign do_pop     = pop_req && head_valid;

  always_comb begin
    wr_ptr_nxt = push.valid ? wr_ptr_r + PTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + PTR_W'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r + lss_pkg::QCNT_W'(push.valid) - lss_pkg::QCNT_W'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.valid) begin
      mem_r[wr_ptr_r] <= push.job;
    end
  end

endmodule

@@ hdl/lss_front.sv @@
// ----------------------------------------------------------------------------
// lss_front
// Accepts and classifies items, keeps the line stores and the 3x2 window.
// ----------------------------------------------------------------------------
module lss_front (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        in_mode,
  input  logic [7:0]                  in_alpha_in,
  input  logic [7:0]                  in_red_in,
  input  logic [7:0]                  in_green_in,
  input  logic [7:0]                  in_blue_in,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [1:0]                  cfg_index,
  input  logic [15:0]                 cfg_data,
  input  logic [lss_pkg::QCNT_W-1:0]  q_count,
  output lss_pkg::push_t              push,
  output logic [11:0]                 strength
);

  localparam int CW = lss_pkg::COL_W;
  localparam int RW = lss_pkg::ROW_W;

  logic [11:0]   width_r;
  logic [15:0]   height_r;
  logic [11:0]   str_r;
  logic [CW-1:0] col_r, col_nxt;
  logic [RW-1:0] row_r, row_nxt;

  logic          acc, take, flushing, produce, last, col_nz, geo_wr;
  logic [RW-1:0] h_ext, h_p1;
  logic [11:0]   w_in;

  // first stage after acceptance
  logic          s1_v_r, s1_prod_r, s1_last_r, s1_lft_r, s1_rgt_r, s1_oy0_r, s1_oyh_r;
  logic [CW-1:0] s1_addr_r;
  logic [31:0]   s1_pix_r;
  logic          byp_v_r;
  logic [63:0]   byp_d_r;

  logic [63:0]   ram_q, rd_word, wr_word;
  logic [31:0]   top, mid;
  logic [31:0]   wnd_r [6];
  logic [31:0]   cm, cl, cr, ct, cb;

  assign cfg_ready = 1'b1;
  assign strength  = str_r;
  assign geo_wr    = cfg_valid &&
                     (cfg_index == lss_pkg::REG_FRAME_WIDTH ||
                      cfg_index == lss_pkg::REG_FRAME_HEIGHT);

  assign in_ready = ({1'b0, q_count} + (lss_pkg::QCNT_W + 1)'(s1_v_r))
                    < (lss_pkg::QCNT_W + 1)'(lss_pkg::Q_DEPTH);
  assign acc      = in_valid && in_ready;
  assign h_ext    = {1'b0, height_r};
  assign h_p1     = h_ext + RW'(1);
  assign flushing = (row_r >= h_ext);
  assign take     = acc && (flushing || !in_mode);
  assign col_nz   = (col_r != '0);
  assign produce  = (row_r > RW'(1)) || (row_r == RW'(1) && col_nz);
  assign last     = !col_nz && (row_r == h_p1);

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (geo_wr) begin
      col_nxt = '0;
      row_nxt = '0;
    end else if (take) begin
      if (produce && last) begin
        col_nxt = '0;
        row_nxt = '0;
      end else if (({1'b0, col_r} + 12'd1) >= width_r) begin
        col_nxt = '0;
        row_nxt = row_r + RW'(1);
      end else begin
        col_nxt = col_r + CW'(1);
      end
    end
  end

  assign w_in = cfg_data[11:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= lss_pkg::WIDTH_RST;
      height_r <= lss_pkg::HEIGHT_RST;
      str_r    <= lss_pkg::STRENGTH_RST;
      col_r    <= '0;
      row_r    <= '0;
      s1_v_r   <= 1'b0;
      byp_v_r  <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          lss_pkg::REG_FRAME_WIDTH: begin
            if (w_in == '0) begin
              width_r <= 12'd1;
            end else if (w_in > 12'(lss_pkg::MAX_WIDTH)) begin
              width_r <= 12'(lss_pkg::MAX_WIDTH);
            end else begin
              width_r <= w_in;
            end
          end
          lss_pkg::REG_FRAME_HEIGHT: height_r <= (cfg_data == '0) ? 16'd1 : cfg_data;
          lss_pkg::REG_STRENGTH:     str_r    <= cfg_data[11:0];
          default: ;
        endcase
      end
      col_r   <= col_nxt;
      row_r   <= row_nxt;
      s1_v_r  <= take;
      // same-cycle read and write of one column (single-column frames)
      byp_v_r <= s1_v_r && (s1_addr_r == col_r);
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_prod_r <= produce;
      s1_last_r <= last;
      s1_lft_r  <= col_nz ? (col_r > CW'(1)) : (width_r > 12'd1);
      s1_rgt_r  <= col_nz;
      s1_oy0_r  <= col_nz ? (row_r == RW'(1)) : (row_r == RW'(2));
      s1_oyh_r  <= col_nz ? (row_r == h_ext) : (row_r == h_p1);
      s1_addr_r <= col_r;
      s1_pix_r  <= flushing ? 32'd0 : {in_alpha_in, in_red_in, in_green_in, in_blue_in};
    end
    byp_d_r <= wr_word;
  end

  lss_ram #(.WIDTH(64), .DEPTH(lss_pkg::MAX_WIDTH)) u_rows (
    .clk     (clk),
    .wr_en   (s1_v_r),
    .wr_addr (s1_addr_r),
    .wr_data (wr_word),
    .rd_addr (col_r),
    .rd_data (ram_q)
  );

  assign rd_word = byp_v_r ? byp_d_r : ram_q;
  assign top     = rd_word[63:32];
  assign mid     = rd_word[31:0];
  assign wr_word = {mid, s1_pix_r};

  assign cm = wnd_r[1];
  assign ct = s1_oy0_r ? cm : wnd_r[0];
  assign cb = s1_oyh_r ? cm : wnd_r[2];
  assign cl = s1_lft_r ? wnd_r[4] : cm;
  assign cr = s1_rgt_r ? mid : cm;

  always_comb begin
    push.valid     = s1_v_r && s1_prod_r;
    push.job.alpha = cm[31:24];
    push.job.cm    = cm[23:0];
    push.job.cl    = cl[23:0];
    push.job.cr    = cr[23:0];
    push.job.ct    = ct[23:0];
    push.job.cb    = cb[23:0];
    push.job.last  = s1_last_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || geo_wr || (s1_v_r && s1_prod_r && s1_last_r)) begin
      for (int i = 0; i < 6; i++) begin
        wnd_r[i] <= '0;
      end
    end else if (s1_v_r) begin
      wnd_r[3] <= wnd_r[0];
      wnd_r[4] <= wnd_r[1];
      wnd_r[5] <= wnd_r[2];
      wnd_r[0] <= top;
      wnd_r[1] <= mid;
      wnd_r[2] <= s1_pix_r;
    end
  end

endmodule

@@ hdl/lss_back.sv @@
// ----------------------------------------------------------------------------
// lss_back
// Laplacian, strength multiply, floor and clamp, with the output register.
// ----------------------------------------------------------------------------
module lss_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          head_valid,
  input  lss_pkg::job_t head,
  output logic          pop,
  input  logic [11:0]   strength,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [7:0]    out_alpha_out,
  output logic [7:0]    out_red_out,
  output logic [7:0]    out_green_out,
  output logic [7:0]    out_blue_out,
  output logic          out_last_of_frame
);

  logic        en;
  logic        b1_v_r, b2_v_r, o_v_r;
  logic [7:0]  b1_a_r, b2_a_r;
  logic [23:0] b1_c_r, b2_c_r;
  logic        b1_l_r, b2_l_r;
  logic [10:0] b1_d_r [3];
  logic signed [22:0] b2_p_r [3];
  logic [10:0] d_nxt [3];
  logic signed [22:0] p_nxt [3];
  logic [7:0]  q_nxt [3];
  logic [7:0]  o_a_r, o_r_r, o_g_r, o_b_r;
  logic        o_l_r;

  assign en  = !o_v_r || out_ready;
  assign pop = en;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      d_nxt[k] = {1'b0, head.cm[8*k +: 8], 2'b00}
               - {3'b0, head.cl[8*k +: 8]} - {3'b0, head.cr[8*k +: 8]}
               - {3'b0, head.ct[8*k +: 8]} - {3'b0, head.cb[8*k +: 8]};
      p_nxt[k] = $signed(b1_d_r[k]) * $signed(strength);
    end
  end

  // v = 256*c + s*d, then floor to an integer and clamp; alpha 0 passes the centre through
  always_comb begin
    logic signed [23:0] v;
    for (int k = 0; k < 3; k++) begin
      v = $signed({8'b0, b2_c_r[8*k +: 8], 8'b0}) + $signed({b2_p_r[k][22], b2_p_r[k]});
      if (b2_a_r == 8'd0) begin
        q_nxt[k] = b2_c_r[8*k +: 8];
      end else if (v[23]) begin
        q_nxt[k] = 8'd0;
      end else if (v[22:16] != '0) begin
        q_nxt[k] = 8'd255;
      end else begin
        q_nxt[k] = v[15:8];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b1_v_r <= 1'b0;
      b2_v_r <= 1'b0;
      o_v_r  <= 1'b0;
    end else if (en) begin
      b1_v_r <= head_valid;
      b2_v_r <= b1_v_r;
      o_v_r  <= b2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b1_a_r <= head.alpha;
      b1_c_r <= head.cm;
      b1_l_r <= head.last;
      b2_a_r <= b1_a_r;
      b2_c_r <= b1_c_r;
      b2_l_r <= b1_l_r;
      for (int k = 0; k < 3; k++) begin
        b1_d_r[k] <= d_nxt[k];
        b2_p_r[k] <= p_nxt[k];
      end
      o_a_r <= b2_a_r;
      o_b_r <= q_nxt[0];
      o_g_r <= q_nxt[1];
      o_r_r <= q_nxt[2];
      o_l_r <= b2_l_r;
    end
  end

  assign out_valid         = o_v_r;
  assign out_alpha_out     = o_a_r;
  assign out_red_out       = o_r_r;
  assign out_green_out     = o_g_r;
  assign out_blue_out      = o_b_r;
  assign out_last_of_frame = o_l_r;

endmodule

@@ hdl/laplacian_sharpen_stream.sv @@
// Throughput: one item per cycle while the queue has room; line-store read at acceptance.
// Ordering: a pixel's result is carried by the item frame_width + 1 places later and
//   leaves after that item's transfer through the window stage, queue and three back stages.
// Reset: synchronous, active low; registers return to 640 x 480, strength 1.0, position
//   and window cleared. Line stores are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
// laplacian_sharpen_stream
// Streaming 5-point Laplacian sharpener for ARGB pixels in raster order.
// ----------------------------------------------------------------------------
module laplacian_sharpen_stream (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_mode,
  input  logic [7:0]  in_alpha_in,
  input  logic [7:0]  in_red_in,
  input  logic [7:0]  in_green_in,
  input  logic [7:0]  in_blue_in,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_alpha_out,
  output logic [7:0]  out_red_out,
  output logic [7:0]  out_green_out,
  output logic [7:0]  out_blue_out,
  output logic        out_last_of_frame,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  lss_pkg::push_t                push;
  lss_pkg::job_t                 head;
  logic                          head_valid, pop;
  logic [lss_pkg::QCNT_W-1:0]    q_count;
  logic [11:0]                   strength;

  lss_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_mode     (in_mode),
    .in_alpha_in (in_alpha_in),
    .in_red_in   (in_red_in),
    .in_green_in (in_green_in),
    .in_blue_in  (in_blue_in),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .q_count     (q_count),
    .push        (push),
    .strength    (strength)
  );

  lss_fifo u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .pop_req    (pop),
    .head_valid (head_valid),
    .head       (head),
    .count      (q_count)
  );

  lss_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .head_valid        (head_valid),
    .head              (head),
    .pop               (pop),
    .strength          (strength),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_alpha_out     (out_alpha_out),
    .out_red_out       (out_red_out),
    .out_green_out     (out_green_out),
    .out_blue_out      (out_blue_out),
    .out_last_of_frame (out_last_of_frame)
  );

  // queue never overfills: acceptance reserves room for the job in flight
  a_q_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_count <= lss_pkg::QCNT_W'(lss_pkg::Q_DEPTH))
    else $error("job queue overflow");

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    push.valid |-> (q_count < lss_pkg::QCNT_W'(lss_pkg::Q_DEPTH) || pop))
    else $error("push into full queue");

  a_ready_room: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> q_count < lss_pkg::QCNT_W'(lss_pkg::Q_DEPTH))
    else $error("ready with no queue room");

endmodule

@@ verif/laplacian_sharpen_stream_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// laplacian_sharpen_stream_tb
// Drives ARGB raster frames with drain items into the sharpener and checks
// every result pixel against a cycle-free model of the 5-point cross filter,
// kept in step with each accepted input transfer. Sender gaps and receiver
// stalls are varied per phase.
// ----------------------------------------------------------------------------
module laplacian_sharpen_stream_tb;

  localparam int LIMIT    = 1000000;
  localparam int SETTLE   = 16;
  localparam int RAND_ITEMS = 650;

  typedef enum int {PH_FREE, PH_SRC_IDLE, PH_SINK_STALL, PH_BOTH} phase_t;
  typedef enum bit {MODE_PIXEL = 1'b0, MODE_DRAIN = 1'b1} mode_t;

  typedef struct {
    logic [7:0] a, r, g, b;
    logic       last;
  } pix_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_mode = 1'b0;
  logic [7:0] in_alpha_in = 8'd0, in_red_in = 8'd0, in_green_in = 8'd0, in_blue_in = 8'd0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [7:0] out_alpha_out, out_red_out, out_green_out, out_blue_out;
  logic out_last_of_frame;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = lss_pkg::REG_FRAME_WIDTH;
  logic [15:0] cfg_data = 16'd0;

  laplacian_sharpen_stream uut (.*);

  always #10 clk = ~clk;

  // sharpener model state
  logic [31:0] line_above [lss_pkg::MAX_WIDTH];
  logic [31:0] line_centre [lss_pkg::MAX_WIDTH];
  logic [31:0] win [6];
  int unsigned col_pos, row_pos, owed;
  logic [11:0] fw;
  logic [15:0] fh;
  logic signed [11:0] gain;
  bit frame_done;

  pix_t expected_pix[$];
  int errors = 0;
  int cycles = 0;
  int items_sent = 0;
  phase_t phase = PH_FREE;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("laplacian_sharpen_stream: mismatch");
      $finish;
    end
  end

  task automatic report(input string what, input int got, input int want);
    $display("ERROR @%0d: %s got %0d want %0d", cycles, what, got, want);
    errors++;
  endtask

  function automatic void restart_frame();
    col_pos = 0;
    row_pos = 0;
    owed = 0;
    for (int i = 0; i < 6; i++) win[i] = 32'd0;
  endfunction

  function automatic logic [7:0] sharpen(input logic [7:0] c, l, r, t, b);
    int d, v;
    d = 4 * int'(c) - int'(l) - int'(r) - int'(t) - int'(b);
    v = int'(c) * 256 + int'(gain) * d;
    if (v < 0) return 8'd0;
    v = v / 256;
    if (v > 255) v = 255;
    return v[7:0];
  endfunction

  function automatic void sharpen_predict(input logic md, input logic [31:0] px);
    int unsigned w, h, c, rr, ox, oy;
    bit flushing, lst;
    logic [31:0] top, mid, bot, ct, cm, cb, cl, cr;
    pix_t e;
    w = (fw == 0) ? 1 : ((fw > lss_pkg::MAX_WIDTH) ? lss_pkg::MAX_WIDTH : fw);
    h = (fh == 0) ? 1 : fh;
    flushing = row_pos >= h;
    c = col_pos;
    rr = row_pos;
    if (!flushing && md == MODE_DRAIN) return;
    if (c >= lss_pkg::MAX_WIDTH) c = 0;
    bot = flushing ? 32'd0 : px;
    top = line_above[c];
    mid = line_centre[c];
    line_above[c] = mid;
    line_centre[c] = bot;
    if (rr > 1 || (rr == 1 && c > 0)) begin
      ox = (c > 0) ? c - 1 : w - 1;
      oy = (c > 0) ? rr - 1 : rr - 2;
      ct = win[0];
      cm = win[1];
      cb = win[2];
      cl = (ox > 0) ? win[4] : cm;
      cr = (ox + 1 < w) ? mid : cm;
      lst = (ox == w - 1) && (oy == h - 1);
      if (oy == 0) ct = cm;
      if (oy == h - 1) cb = cm;
      e.a = cm[31:24];
      if (cm[31:24] == 8'd0) begin
        e.r = cm[23:16];
        e.g = cm[15:8];
        e.b = cm[7:0];
      end else begin
        e.r = sharpen(cm[23:16], cl[23:16], cr[23:16], ct[23:16], cb[23:16]);
        e.g = sharpen(cm[15:8], cl[15:8], cr[15:8], ct[15:8], cb[15:8]);
        e.b = sharpen(cm[7:0], cl[7:0], cr[7:0], ct[7:0], cb[7:0]);
      end
      e.last = lst;
      expected_pix.push_back(e);
      if (lst) begin
        restart_frame();
        frame_done = 1;
        return;
      end
    end
    win[3] = win[0];
    win[4] = win[1];
    win[5] = win[2];
    win[0] = top;
    win[1] = mid;
    win[2] = bot;
    if (flushing && owed > 0) owed--;
    c++;
    if (c >= w) begin
      c = 0;
      rr++;
      if (rr == h) owed = (w + 1) & 12'hfff;
    end
    col_pos = c;
    row_pos = rr;
  endfunction

  // result checker and receiver stalls
  always @(posedge clk) begin
    pix_t e;
    if (out_valid && out_ready) begin
      if (expected_pix.size() == 0) begin
        report("unexpected result, alpha", out_alpha_out, -1);
      end else begin
        e = expected_pix.pop_front();
        if (out_alpha_out !== e.a) report("alpha", out_alpha_out, e.a);
        if (out_red_out !== e.r) report("red", out_red_out, e.r);
        if (out_green_out !== e.g) report("green", out_green_out, e.g);
        if (out_blue_out !== e.b) report("blue", out_blue_out, e.b);
        if (out_last_of_frame !== e.last) report("last_of_frame", out_last_of_frame, e.last);
      end
    end
    if (rst_n && phase == PH_SINK_STALL)
      out_ready <= ($urandom_range(0, 99) >= 58);
    else if (rst_n && phase == PH_BOTH)
      out_ready <= ($urandom_range(0, 99) >= 13);
    else
      out_ready <= rst_n;
  end

  task automatic send_item(input logic md, input logic [31:0] px);
    int idle_pct;
    idle_pct = (phase == PH_BOTH) ? 13 : 58;
    if (phase == PH_SRC_IDLE || phase == PH_BOTH) begin
      if ($urandom_range(0, 99) < idle_pct) begin
        in_valid <= 1'b0;
        do @(posedge clk); while ($urandom_range(0, 99) < idle_pct);
      end
    end
    in_valid <= 1'b1;
    in_mode <= md;
    {in_alpha_in, in_red_in, in_green_in, in_blue_in} <= px;
    do @(posedge clk); while (!in_ready);
    sharpen_predict(md, px);
    items_sent++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_pix.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      lss_pkg::REG_FRAME_WIDTH: begin
        fw = val[11:0];
        restart_frame();
      end
      lss_pkg::REG_FRAME_HEIGHT: begin
        fh = val;
        restart_frame();
      end
      lss_pkg::REG_STRENGTH: gain = val[11:0];
      default: ;
    endcase
  endtask

  task automatic set_geometry(input logic [11:0] w, input logic [15:0] h,
                              input logic [11:0] s);
    wait_drained();
    write_reg(lss_pkg::REG_FRAME_WIDTH, {4'd0, w});
    write_reg(lss_pkg::REG_FRAME_HEIGHT, h);
    write_reg(lss_pkg::REG_STRENGTH, {4'd0, s});
  endtask

  function automatic logic [31:0] rand_pixel();
    logic [31:0] p;
    p = $urandom;
    if ($urandom_range(0, 7) == 0) p[31:24] = 8'd0;
    if ($urandom_range(0, 5) == 0) p[23:0] = {3{($urandom_range(0, 1) != 0) ? 8'hff : 8'h00}};
    return p;
  endfunction

  // pixels with stray drains, then mostly drains, until the frame's last result is predicted
  task automatic run_frame();
    bit in_frame;
    frame_done = 0;
    while (!frame_done) begin
      in_frame = row_pos < ((fh == 0) ? 1 : fh);
      if (in_frame)
        send_item(($urandom_range(0, 15) == 0) ? MODE_DRAIN : MODE_PIXEL, rand_pixel());
      else
        send_item(($urandom_range(0, 3) != 0) ? MODE_DRAIN : MODE_PIXEL, rand_pixel());
    end
  endtask

  task automatic test_directed();
    phase = PH_FREE;
    // single pixel frame, strongest positive gain
    set_geometry(12'd1, 16'd1, 12'h7ff);
    frame_done = 0;
    send_item(MODE_PIXEL, 32'hffff_0000);
    while (!frame_done) send_item(MODE_DRAIN, 32'd0);
    // 3x3 with extremes, alpha 0 centre, drain mid-frame, pixel during flush
    set_geometry(12'd3, 16'd3, 12'h800);
    frame_done = 0;
    send_item(MODE_PIXEL, 32'hffff_ffff);
    send_item(MODE_PIXEL, 32'h0100_0000);
    send_item(MODE_DRAIN, 32'h0);
    send_item(MODE_PIXEL, 32'h80ff_00ff);
    send_item(MODE_PIXEL, 32'h0012_3456);
    send_item(MODE_PIXEL, 32'h0000_0000);
    send_item(MODE_PIXEL, 32'hff00_ff00);
    send_item(MODE_PIXEL, 32'h7f7f_7f7f);
    send_item(MODE_PIXEL, 32'hfe01_fe01);
    send_item(MODE_PIXEL, 32'h01ff_ffff);
    send_item(MODE_PIXEL, 32'hdead_beef);
    while (!frame_done) send_item(MODE_DRAIN, 32'd0);
    // zero sizes act as one, zero gain
    set_geometry(12'd0, 16'd0, 12'd0);
    frame_done = 0;
    send_item(MODE_PIXEL, 32'h55aa_55aa);
    while (!frame_done) send_item(MODE_DRAIN, 32'd0);
  endtask

  task automatic test_random_frames();
    int n;
    n = 0;
    while (items_sent < RAND_ITEMS + 25) begin
      phase = phase_t'(n % 4);
      case ($urandom_range(0, 9))
        0: set_geometry(12'd0, 16'd0, 12'($urandom));
        1: set_geometry(12'($urandom_range(1, 24)), 16'($urandom_range(1, 3)),
                        12'($urandom));
        2: set_geometry(12'($urandom_range(1, 8)), 16'($urandom_range(1, 5)),
                        ($urandom_range(0, 1) != 0) ? 12'h7ff : 12'h800);
        default: set_geometry(12'($urandom_range(1, 8)), 16'($urandom_range(1, 6)),
                              12'($urandom));
      endcase
      run_frame();
      n++;
    end
  endtask

  task automatic test_wide_frame();
    int i;
    phase = PH_BOTH;
    // width above the store depth: no result is due before the row wraps,
    // the partial frame is dropped by the next geometry write
    set_geometry(12'hfff, 16'd1, 12'd128);
    for (i = 0; i < 200; i++) send_item(MODE_PIXEL, rand_pixel());
    wait_drained();
  endtask

  task automatic test_tall_abort();
    int i;
    phase = PH_SRC_IDLE;
    set_geometry(12'd2, 16'hffff, 12'd300);
    for (i = 0; i < 20; i++) send_item(MODE_PIXEL, rand_pixel());
    // sender holds off until every result so far has come, then gain changes
    wait_drained();
    write_reg(lss_pkg::REG_STRENGTH, 16'h0f00);
    for (i = 0; i < 20; i++) send_item(MODE_PIXEL, rand_pixel());
    // geometry write mid-frame drops the rest
    wait_drained();
    write_reg(lss_pkg::REG_FRAME_HEIGHT, 16'd2);
    phase = PH_SINK_STALL;
    run_frame();
  endtask

  initial begin
    for (int i = 0; i < lss_pkg::MAX_WIDTH; i++) begin
      line_above[i] = 32'd0;
      line_centre[i] = 32'd0;
    end
    fw = lss_pkg::WIDTH_RST;
    fh = lss_pkg::HEIGHT_RST;
    gain = lss_pkg::STRENGTH_RST;
    restart_frame();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random_frames();
    test_wide_frame();
    test_tall_abort();
    wait_drained();
    if (errors == 0)
      $display("laplacian_sharpen_stream: match");
    else
      $display("laplacian_sharpen_stream: mismatch");
    $finish;
  end

endmodule

@@ laplacian_sharpen_stream.f @@
hdl/lss_pkg.sv
hdl/lss_ram.sv
hdl/lss_fifo.sv
hdl/lss_front.sv
hdl/lss_back.sv
hdl/laplacian_sharpen_stream.sv
verif/laplacian_sharpen_stream_tb.sv
